@@ rtl/ambient_light_lux_calc_top_macros.svh @@
`ifndef AMBIENT_LIGHT_LUX_CALC_TOP_MACROS_SVH
`define AMBIENT_LIGHT_LUX_CALC_TOP_MACROS_SVH

// check cons in the cycle after ante
`define ALUX_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// check cons in the same cycle as ante
`define ALUX_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ rtl/alux_pkg.sv @@
package alux_pkg;

	localparam int CNT_W  = 16;
	localparam int LUX_W  = 32;
	localparam int GAIN_W = 3;
	localparam int DIV_W  = 9;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic REG_GAIN = 1'b0;
	localparam logic REG_DIV  = 1'b1;

	localparam logic [CNT_W-1:0] CNT_SAT = 16'hFFFF;

	localparam int K_BASE  = 3040 * 65536;
	localparam int C_LO_B  = 6200;
	localparam int C_MID_A = 2240;
	localparam int C_MID_B = 3100;
	localparam int C_HI_A  = 1280;
	localparam int C_HI_B  = 1530;
	localparam int C_TOP_A = 146;
	localparam int C_TOP_B = 112;
	localparam int LUX_SCALE = 402;
	localparam longint unsigned DEN_UNIT = 64'd25600000;

	typedef enum logic [2:0] {
		SEG_LOW  = 3'd0,
		SEG_MID  = 3'd1,
		SEG_HIGH = 3'd2,
		SEG_TOP  = 3'd3,
		SEG_ZERO = 3'd4
	} seg_t;

	typedef struct packed {
		logic [CNT_W-1:0] vis;
		logic [CNT_W-1:0] ir;
		logic             sat;
		seg_t             seg;
	} item_t;

	function automatic longint unsigned iroot5(longint unsigned t);
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned mid;
		lo = 0;
		hi = 4096;
		for (int i = 0; i < 14; i++) begin
			if (lo < hi) begin
				mid = (lo + hi + 1) >> 1;
				if (mid * mid * mid * mid * mid <= t)
					lo = mid;
				else
					hi = mid - 1;
			end
		end
		return lo;
	endfunction

	function automatic logic [15:0] pow_entry(longint unsigned x16);
		longint unsigned v12;
		longint unsigned y12;
		v12 = x16 >> 4;
		y12 = iroot5((v12 * v12) << 36);
		return 16'((x16 * y12) >> 12);
	endfunction

endpackage

@@ rtl/ambient_light_lux_calc_top.sv @@
// Channel   Dir  Signals                          Contents
// s_axis    in   tvalid tready tdata[31:0]        visible, infrared counts
// m_axis    out  tvalid tready tdata[31:0] tuser  lux value, lux valid flag
// apb       in   psel penable pwrite paddr pwdata gain code, integration divisor
//
// One sample pair enters per cycle unless m_axis stalls; the pipeline holds
// the bit-per-stage ratio divider and the 34-stage lux divider.
// Reset: asynchronous, active low; clears valid bits and the registers.
// A stall on m_axis freezes the whole pipeline, bubbles included.
`include "ambient_light_lux_calc_top_macros.svh"

module ambient_light_lux_calc_top #(
	parameter int RATIO_FRAC_BITS = 16,
	parameter int POW_TABLE_DEPTH = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [31:0]                 s_axis_tdata,  // visible_count, infrared_count
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [31:0]                 m_axis_tdata,  // lux_value
	output logic [0:0]                  m_axis_tuser,  // lux_valid
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [alux_pkg::ADDR_W-1:0] paddr,
	input  logic [alux_pkg::DATA_W-1:0] pwdata,
	output logic [alux_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import alux_pkg::*;

	localparam int F  = RATIO_FRAC_BITS;
	localparam int D  = POW_TABLE_DEPTH;
	localparam int PW = F + $clog2(2 * D + 1);
	localparam int IW = $clog2(D + 1);
	localparam int QN = 34;
	localparam int NW = 58;
	localparam int DW = 34;
	localparam int CW = DW + QN;
	localparam int MW = 45;

	logic [GAIN_W-1:0] gain_q;
	logic [DIV_W-1:0]  div_q;
	logic [DW-1:0]     den_q;
	logic              adv;
	logic [DIV_W-1:0]  div_eff;

	logic [15:0] pow_tab [0:D];

	for (genvar t = 0; t <= D; t++) begin : g_tab
		localparam longint unsigned X16 = (longint'(t) << 15) / D;
		assign pow_tab[t] = pow_entry(X16);
	end

	// configuration
	assign pready  = 1'b1;
	assign div_eff = (pwdata[DIV_W-1:0] == '0) ? DIV_W'(1) : pwdata[DIV_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= '0;
			div_q  <= DIV_W'(1);
			den_q  <= DW'(DEN_UNIT);
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_GAIN: gain_q <= pwdata[GAIN_W-1:0];
				REG_DIV: begin
					div_q <= pwdata[DIV_W-1:0];
					den_q <= DW'(DEN_UNIT) * DW'(div_eff);
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_GAIN: prdata = DATA_W'(gain_q);
			REG_DIV:  prdata = DATA_W'(div_q);
			default:  prdata = '0;
		endcase
	end

	// stage 1: segment select
	logic        vld_s1;
	item_t       it_s1;
	logic [15:0] in_vis;
	logic [15:0] in_ir;
	logic [23:0] ir100;
	seg_t        in_seg;

	logic vld_s9;
	assign adv           = !vld_s9 || m_axis_tready;
	assign s_axis_tready = adv;
	assign in_vis        = s_axis_tdata[15:0];
	assign in_ir         = s_axis_tdata[31:16];
	assign ir100         = 24'(in_ir) * 24'd100;

	always_comb begin
		if (in_vis == '0)
			in_seg = SEG_ZERO;
		else if (ir100 < 24'(in_vis) * 24'd50)
			in_seg = SEG_LOW;
		else if (ir100 < 24'(in_vis) * 24'd61)
			in_seg = SEG_MID;
		else if (ir100 < 24'(in_vis) * 24'd80)
			in_seg = SEG_HIGH;
		else if (ir100 < 24'(in_vis) * 24'd130)
			in_seg = SEG_TOP;
		else
			in_seg = SEG_ZERO;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (adv)
			vld_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			it_s1.vis <= in_vis;
			it_s1.ir  <= in_ir;
			it_s1.sat <= (in_vis == CNT_SAT) || (in_ir == CNT_SAT);
			it_s1.seg <= in_seg;
		end
	end

	// stage 2: ratio divider, one quotient bit per stage
	logic          vld_s2 [0:F-1];
	item_t         it_s2  [0:F-1];
	logic [15:0]   rem_s2 [0:F-1];
	logic [F-1:0]  quo_s2 [0:F-1];

	for (genvar g = 0; g < F; g++) begin : g_rdiv
		logic [15:0]  rin;
		logic [F-1:0] qin;
		item_t        iin;
		logic         vin;
		logic [16:0]  sh;
		logic         ge;

		if (g == 0) begin : g_first
			assign rin = (it_s1.seg == SEG_LOW) ? it_s1.ir : '0;
			assign qin = '0;
			assign iin = it_s1;
			assign vin = vld_s1;
		end else begin : g_next
			assign rin = rem_s2[g-1];
			assign qin = quo_s2[g-1];
			assign iin = it_s2[g-1];
			assign vin = vld_s2[g-1];
		end

		assign sh = {rin, 1'b0};
		assign ge = sh >= {1'b0, iin.vis};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s2[g] <= 1'b0;
			else if (adv)
				vld_s2[g] <= vin;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				it_s2[g]  <= iin;
				rem_s2[g] <= ge ? 16'(sh - {1'b0, iin.vis}) : sh[15:0];
				quo_s2[g] <= {qin[F-2:0], ge};
			end
		end
	end

	// stage 3: table lookup
	logic          vld_s3;
	item_t         it_s3;
	logic [15:0]   a_s3;
	logic [15:0]   b_s3;
	logic [F-1:0]  frac_s3;
	logic [PW-1:0] pos;
	logic [PW-F-1:0] idx_raw;
	logic [IW-1:0] idx;
	logic [F-1:0]  frac;

	assign pos     = PW'(quo_s2[F-1]) * PW'(2 * D);
	assign idx_raw = pos[PW-1:F];

	always_comb begin
		if (idx_raw >= (PW-F)'(D)) begin
			idx  = IW'(D - 1);
			frac = '1;
		end else begin
			idx  = idx_raw[IW-1:0];
			frac = pos[F-1:0];
		end
	end

	// stage 4: interpolation
	logic        vld_s4;
	item_t       it_s4;
	logic [15:0] p_s4;
	logic [15:0] diff;
	logic [15+F:0] ip;

	assign diff = b_s3 - a_s3;
	assign ip   = (16+F)'(diff) * (16+F)'(frac_s3);

	// stage 5: segment numerators
	logic               vld_s5;
	item_t              it_s5;
	logic signed [29:0] k_s5;
	logic signed [29:0] num2_s5;
	logic [29:0]        num2;

	always_comb begin
		case (it_s4.seg)
			SEG_MID:  num2 = 30'(32'(C_MID_A) * 32'(it_s4.vis)) - 30'(32'(C_MID_B) * 32'(it_s4.ir));
			SEG_HIGH: num2 = 30'(32'(C_HI_A) * 32'(it_s4.vis)) - 30'(32'(C_HI_B) * 32'(it_s4.ir));
			SEG_TOP:  num2 = 30'(32'(C_TOP_A) * 32'(it_s4.vis)) - 30'(32'(C_TOP_B) * 32'(it_s4.ir));
			default:  num2 = '0;
		endcase
	end

	// stage 6: broadband product
	logic          vld_s6;
	item_t         it_s6;
	logic [MW-1:0] m_s6;
	logic [MW-1:0] m_nxt;

	always_comb begin
		if (it_s5.seg == SEG_LOW)
			m_nxt = (k_s5 > 0) ? MW'(it_s5.vis) * MW'(k_s5[28:0]) : '0;
		else
			m_nxt = (num2_s5 > 0) ? {num2_s5[28:0], 16'b0} : '0;
	end

	// stage 7: lux scaling and gain scaling
	logic          vld_s7;
	item_t         it_s7;
	logic [NW-1:0] n_s7;
	logic [53:0]   n54;

	assign n54 = 54'(m_s6) * 54'(LUX_SCALE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2[F-1];
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			it_s3   <= it_s2[F-1];
			a_s3    <= pow_tab[idx];
			b_s3    <= pow_tab[IW'(idx + 1'b1)];
			frac_s3 <= frac;
			it_s4   <= it_s3;
			p_s4    <= (b_s3 < a_s3) ? a_s3 : 16'(a_s3 + ip[15+F:F]);
			it_s5   <= it_s4;
			k_s5    <= 30'(K_BASE) - 30'(32'(C_LO_B) * 32'(p_s4));
			num2_s5 <= num2;
			it_s6   <= it_s5;
			m_s6    <= m_nxt;
			it_s7   <= it_s6;
			n_s7    <= (gain_q == '0) ? {n54, 4'b0} : {4'b0, n54};
		end
	end

	// stage 8: lux divider, one quotient bit per stage
	logic          vld_s8 [0:QN-1];
	item_t         it_s8  [0:QN-1];
	logic [NW-1:0] rem_s8 [0:QN-1];
	logic [QN-1:0] quo_s8 [0:QN-1];

	for (genvar j = 0; j < QN; j++) begin : g_ldiv
		localparam int SH = QN - 1 - j;
		logic [NW-1:0] rin;
		logic [QN-1:0] qin;
		item_t         iin;
		logic          vin;
		logic [CW-1:0] dsh;
		logic          ge;

		if (j == 0) begin : g_first
			assign rin = n_s7;
			assign qin = '0;
			assign iin = it_s7;
			assign vin = vld_s7;
		end else begin : g_next
			assign rin = rem_s8[j-1];
			assign qin = quo_s8[j-1];
			assign iin = it_s8[j-1];
			assign vin = vld_s8[j-1];
		end

		assign dsh = CW'(den_q) << SH;
		assign ge  = CW'(rin) >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s8[j] <= 1'b0;
			else if (adv)
				vld_s8[j] <= vin;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				it_s8[j]  <= iin;
				rem_s8[j] <= ge ? NW'(CW'(rin) - dsh) : rin;
				quo_s8[j] <= {qin[QN-2:0], ge};
			end
		end
	end

	// stage 9: saturate and hold for the output
	logic [LUX_W-1:0] lux_s9;
	logic             ok_s9;
	logic [QN-1:0]    qf;

	assign qf = quo_s8[QN-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s9 <= 1'b0;
		else if (adv)
			vld_s9 <= vld_s8[QN-1];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s9 <= !it_s8[QN-1].sat;
			if (it_s8[QN-1].sat)
				lux_s9 <= '0;
			else if (qf[QN-1:LUX_W] != '0)
				lux_s9 <= '1;
			else
				lux_s9 <= qf[LUX_W-1:0];
		end
	end

	assign m_axis_tvalid   = vld_s9;
	assign m_axis_tdata    = lux_s9;
	assign m_axis_tuser[0] = ok_s9;

	`ALUX_ASSERT_NEXT(a_sat_capture, s_axis_tvalid && s_axis_tready && s_axis_tdata[15:0] == CNT_SAT, it_s1.sat, "saturated count not flagged")
	`ALUX_ASSERT_NOW(a_ratio_rem, vld_s2[F-1] && it_s2[F-1].seg == SEG_LOW, rem_s2[F-1] < it_s2[F-1].vis, "ratio remainder out of range")
	`ALUX_ASSERT_NOW(a_ratio_half, vld_s2[F-1] && it_s2[F-1].seg == SEG_LOW, !quo_s2[F-1][F-1], "low segment ratio not below one half")

endmodule

@@ verif/ambient_light_lux_calc_top_tb.sv @@
module ambient_light_lux_calc_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import alux_pkg::*;

	localparam int FRAC_BITS = 16;
	localparam int TAB_DEPTH = 64;
	localparam int PIPE_LAT = FRAC_BITS + 41;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [CNT_W-1:0] ir;
		logic [CNT_W-1:0] vis;
	} sample_t;

	typedef struct packed {
		logic [LUX_W-1:0] lux;
		logic valid;
	} lux_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic [0:0] m_axis_tuser;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	ambient_light_lux_calc_top #(
		.RATIO_FRAC_BITS(FRAC_BITS),
		.POW_TABLE_DEPTH(TAB_DEPTH)
	) dut (.*);

	always #5 clk = ~clk;

	sample_t sample_q[$];
	lux_t lux_q[$];
	longint unsigned pow_tab[TAB_DEPTH+1];
	logic [GAIN_W-1:0] gain_reg;
	logic [DIV_W-1:0] div_reg;
	int errors = 0;
	longint cycles = 0;
	bit hold_sink = 1'b0;
	bit feed_on = 1'b0;
	int src_gap = 0;
	int snk_gap = 0;

	function automatic longint unsigned fifth_root(longint unsigned t);
		longint unsigned lo, hi, mid;
		lo = 0;
		hi = 4096;
		while (lo < hi) begin
			mid = (lo + hi + 1) >> 1;
			if (mid * mid * mid * mid * mid <= t) lo = mid;
			else hi = mid - 1;
		end
		return lo;
	endfunction

	function automatic longint unsigned pow_interp(longint unsigned r);
		longint unsigned pos, idx, frac, a, b;
		pos = (r << 1) * TAB_DEPTH;
		idx = pos >> FRAC_BITS;
		frac = pos & ((64'd1 << FRAC_BITS) - 1);
		if (idx >= TAB_DEPTH) begin
			idx = TAB_DEPTH - 1;
			frac = (64'd1 << FRAC_BITS) - 1;
		end
		a = pow_tab[idx];
		b = pow_tab[idx+1];
		if (b < a) return a;
		return a + (((b - a) * frac) >> FRAC_BITS);
	endfunction

	function automatic lux_t predict_lux(sample_t s);
		longint unsigned vis, ir, g, d, lux;
		longint num;
		lux_t res;
		vis = s.vis;
		ir = s.ir;
		g = (gain_reg == 0) ? 16 : 1;
		d = (div_reg == 0) ? 1 : div_reg;
		lux = 0;
		num = 0;
		if (s.vis == CNT_SAT || s.ir == CNT_SAT) begin
			res.lux = '0;
			res.valid = 1'b0;
			return res;
		end
		if (vis != 0) begin
			if (ir * 100 < vis * 50) begin
				num = longint'(vis) * (64'sd3040 * 65536
					- 64'sd6200 * longint'(pow_interp((ir << FRAC_BITS) / vis)));
				if (num > 0) lux = (longint'(num) * 402 * g) / (64'd25600000 * d);
			end else begin
				if (ir * 100 < vis * 61) num = 2240 * longint'(vis) - 3100 * longint'(ir);
				else if (ir * 100 < vis * 80) num = 1280 * longint'(vis) - 1530 * longint'(ir);
				else if (ir * 100 < vis * 130) num = 146 * longint'(vis) - 112 * longint'(ir);
				if (num > 0) lux = (longint'(num) * 402 * g * 256) / (64'd100000 * d);
			end
		end
		res.lux = (lux > 64'hFFFFFFFF) ? 32'hFFFFFFFF : lux[31:0];
		res.valid = 1'b1;
		return res;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			lux_q.push_back(predict_lux(sample_t'(s_axis_tdata)));
			void'(sample_q.pop_front());
		end
		if (s_axis_tvalid && !s_axis_tready) begin
		end else if (src_gap > 0) begin
			src_gap <= src_gap - 1;
			s_axis_tvalid <= 1'b0;
		end else if (feed_on && sample_q.size() > 0) begin
			s_axis_tvalid <= 1'b1;
			s_axis_tdata <= sample_q[0];
			if ($urandom_range(0, 9) < 2)
				src_gap <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
		end else begin
			s_axis_tvalid <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			if (lux_q.size() == 0) begin
				$display("%0t unexpected lux %h valid %b", $time, m_axis_tdata, m_axis_tuser);
				errors++;
			end else begin
				if (m_axis_tdata !== lux_q[0].lux || m_axis_tuser[0] !== lux_q[0].valid) begin
					$display("%0t mismatch: expected lux %h valid %b, actual lux %h valid %b",
						$time, lux_q[0].lux, lux_q[0].valid, m_axis_tdata, m_axis_tuser);
					errors++;
				end
				void'(lux_q.pop_front());
			end
		end
		if (hold_sink) begin
			m_axis_tready <= 1'b0;
		end else if (snk_gap > 0) begin
			snk_gap <= snk_gap - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			if ($urandom_range(0, 9) < 2)
				snk_gap <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
		end
	end

	task automatic apb_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_W'(4 * REG_GAIN)) gain_reg = data[GAIN_W-1:0];
		else div_reg = data[DIV_W-1:0];
	endtask

	task automatic drain();
		feed_on = 1'b1;
		while (sample_q.size() > 0 || s_axis_tvalid || lux_q.size() > 0) @(posedge clk);
		repeat (PIPE_LAT + 5) @(posedge clk);
	endtask

	task automatic push_sample(logic [15:0] vis, logic [15:0] ir);
		sample_t s;
		s.vis = vis;
		s.ir = ir;
		sample_q.push_back(s);
	endtask

	task automatic push_random();
		logic [15:0] v, i;
		int kind;
		kind = $urandom_range(0, 9);
		v = 16'($urandom);
		if (kind == 0) v = 16'hFFFF;
		else if (kind == 1) v = 16'($urandom_range(0, 40));
		case ($urandom_range(0, 5))
			0: i = 16'($urandom);
			1: i = 16'((32'(v) * $urandom_range(0, 50)) / 100);
			2: i = 16'((32'(v) * $urandom_range(50, 61)) / 100);
			3: i = 16'((32'(v) * $urandom_range(61, 80)) / 100);
			4: i = 16'((32'(v) * $urandom_range(80, 131)) / 100);
			default: i = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(0, 300));
		endcase
		push_sample(v, i);
	endtask

	initial begin
		logic [GAIN_W-1:0] gains[6];
		logic [DIV_W-1:0] divs[6];
		longint unsigned x, v12;
		for (int k = 0; k <= TAB_DEPTH; k++) begin
			x = (longint'(k) << 15) / TAB_DEPTH;
			v12 = x >> 4;
			pow_tab[k] = (x * fifth_root((v12 * v12) << 36)) >> 12;
		end
		gain_reg = 0;
		div_reg = 1;
		gains = '{0, 1, 7, 0, 3, 0};
		divs = '{1, 402, 100, 0, 511, 13};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_sample(0, 0);
		push_sample(16'hFFFF, 0);
		push_sample(0, 16'hFFFF);
		push_sample(16'hFFFF, 16'hFFFF);
		push_sample(16'hFFFE, 0);
		push_sample(16'hFFFE, 16'hFFFE);
		push_sample(0, 100);
		push_sample(1000, 0);
		push_sample(1000, 499);
		push_sample(1000, 500);
		push_sample(1000, 609);
		push_sample(1000, 610);
		push_sample(1000, 799);
		push_sample(1000, 800);
		push_sample(1000, 1299);
		push_sample(1000, 1300);
		push_sample(1, 0);
		push_sample(16'hAAAA, 16'h5555);
		push_sample(16'h5555, 16'h2AAA);
		push_sample(65534, 32766);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			apb_write(ADDR_W'(4 * REG_GAIN), DATA_W'(gains[ph]));
			apb_write(ADDR_W'(4 * REG_DIV), DATA_W'(divs[ph]));
			if (ph == 2) begin
				feed_on = 1'b1;
				hold_sink = 1'b1;
				for (int n = 0; n < 150; n++) push_random();
				repeat (400) @(posedge clk);
				hold_sink = 1'b0;
			end
			for (int n = 0; n < 250; n++) push_random();
			drain();
		end

		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

@@ files.f @@
+incdir+rtl
rtl/alux_pkg.sv
rtl/ambient_light_lux_calc_top.sv
verif/ambient_light_lux_calc_top_tb.sv
